/* hdl/descending_list_merge_assert.svh */
// Assertion macros for the descending list merge block.
// Included by the top level; depends on nothing else.
`ifndef DESCENDING_LIST_MERGE_ASSERT_SVH
`define DESCENDING_LIST_MERGE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLM_ASSERT_SAME(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DLM_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dlm_pkg.sv */
// Shared types and constants for the descending list merge block.
// No dependencies; used by the cell, the chain and the top level.
package dlm_pkg;

  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned DATA_W         = 32;

  // List selector codes carried in tuser.
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  typedef enum logic {
    ST_LOAD,
    ST_MERGE
  } state_e;

  // Control broadcast along a chain of cells.
  typedef struct packed {
    logic load;
    logic pop;
  } cell_ctrl_t;

endpackage

/* hdl/descending_list_merge.sv */
// Channel | Direction | Contents
// s_axis  | in        | tdata: value[31:0]; tuser: list_select (0 list A, 1 list B)
// m_axis  | out       | tdata: merged_value[31:0]; tlast: last_of_run
//
// Loading takes one request per cycle into two chains of LIST_DEPTH cells.
// Once both lists have ended, the merge emits one result per cycle, up to
// 2*LIST_DEPTH results, set by the single compare of the two chain heads.
// The input side is held off for the whole merge; output stalls pause it.
// Reset (rst_ni low, asynchronous) empties both chains and clears counts.
// Top level of the descending list merge; depends on dlm_pkg, dlm_chain
// and the assertion macro header.
`include "descending_list_merge_assert.svh"

module descending_list_merge import dlm_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  logic              s_axis_tuser,   // [0] list_select
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] merged_value
  output logic              m_axis_tlast
);

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned TOT_W = CNT_W + 1;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic              end_a_q, end_a_d, end_b_q, end_b_d;
  logic              out_valid_q, out_valid_d;
  logic              out_last_q, out_last_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic [TOT_W-1:0]  total_q, total_d;

  cell_ctrl_t        ctrl_a, ctrl_b;
  logic              head_a_valid, head_b_valid;
  logic [DATA_W-1:0] head_a_data, head_b_data;

  logic              accept, sel_b, val_zero, fire, pick_a;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign sel_b    = (s_axis_tuser == SEL_B);
  assign val_zero = (s_axis_tdata == '0);
  assign total_q  = TOT_W'(cnt_a_q) + TOT_W'(cnt_b_q);
  assign total_d  = TOT_W'(cnt_a_d) + TOT_W'(cnt_b_d);

  // The output register frees up when empty or when its request is taken.
  assign fire   = (state_q == ST_MERGE) && (!out_valid_q || m_axis_tready);
  assign pick_a = head_a_valid &&
                  (!head_b_valid || ($signed(head_a_data) >= $signed(head_b_data)));

  // Load control, merge sequencing and the output register.
  always_comb begin
    state_d     = state_q;
    cnt_a_d     = cnt_a_q;
    cnt_b_d     = cnt_b_q;
    end_a_d     = end_a_q;
    end_b_d     = end_b_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;
    ctrl_a      = '0;
    ctrl_b      = '0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (!sel_b && !end_a_q) begin
            if (val_zero) begin
              end_a_d = 1'b1;
            end else begin
              ctrl_a.load = 1'b1;
              cnt_a_d     = cnt_a_q + CNT_W'(1);
              end_a_d     = (cnt_a_q == CNT_W'(LIST_DEPTH - 1));
            end
          end
          if (sel_b && !end_b_q) begin
            if (val_zero) begin
              end_b_d = 1'b1;
            end else begin
              ctrl_b.load = 1'b1;
              cnt_b_d     = cnt_b_q + CNT_W'(1);
              end_b_d     = (cnt_b_q == CNT_W'(LIST_DEPTH - 1));
            end
          end
          // Two empty lists produce nothing and clear straight away.
          if (end_a_d && end_b_d) begin
            if (total_d == '0) begin
              end_a_d = 1'b0;
              end_b_d = 1'b0;
            end else begin
              state_d = ST_MERGE;
            end
          end
        end
      end
      ST_MERGE: begin
        if (fire) begin
          out_valid_d = 1'b1;
          out_last_d  = (total_q == TOT_W'(1));
          if (pick_a) begin
            ctrl_a.pop = 1'b1;
            out_data_d = head_a_data;
            cnt_a_d    = cnt_a_q - CNT_W'(1);
          end else begin
            ctrl_b.pop = 1'b1;
            out_data_d = head_b_data;
            cnt_b_d    = cnt_b_q - CNT_W'(1);
          end
          if (total_q == TOT_W'(1)) begin
            state_d = ST_LOAD;
            end_a_d = 1'b0;
            end_b_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      end_a_q     <= 1'b0;
      end_b_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      end_a_q     <= end_a_d;
      end_b_q     <= end_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  // List storage chains.
  dlm_chain #(.LIST_DEPTH(LIST_DEPTH)) u_chain_a (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl_a),
    .load_data_i  (s_axis_tdata),
    .head_valid_o (head_a_valid),
    .head_data_o  (head_a_data)
  );

  dlm_chain #(.LIST_DEPTH(LIST_DEPTH)) u_chain_b (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl_b),
    .load_data_i  (s_axis_tdata),
    .head_valid_o (head_b_valid),
    .head_data_o  (head_b_data)
  );

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // A merge never runs with nothing left to emit.
  `DLM_ASSERT_SAME(a_merge_nonempty, clk_i, rst_ni, state_q == ST_MERGE, total_q != '0, "merge with empty lists")
  // Each chain head is filled exactly when its count is nonzero.
  `DLM_ASSERT_SAME(a_head_a_count, clk_i, rst_ni, 1'b1, head_a_valid == (cnt_a_q != '0), "chain A out of step with count")
  `DLM_ASSERT_SAME(a_head_b_count, clk_i, rst_ni, 1'b1, head_b_valid == (cnt_b_q != '0), "chain B out of step with count")
  // The final merge pop returns the block to loading.
  `DLM_ASSERT_NEXT(a_last_returns, clk_i, rst_ni, fire && total_q == TOT_W'(1), state_q == ST_LOAD && !end_a_q && !end_b_q, "merge did not finish")

endmodule

/* hdl/dlm_cell.sv */
// One storage cell of a list chain: holds a value and its valid flag.
// Depends on dlm_pkg for the control struct and data width.
module dlm_cell import dlm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] load_data_i,
  input  logic              prev_valid_i,
  input  logic              next_valid_i,
  input  logic [DATA_W-1:0] next_data_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic              valid_q, valid_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic              take_load;

  // A load lands in the first empty cell behind the filled ones.
  assign take_load = ctrl_i.load && !valid_q && prev_valid_i;

  // A pop moves every cell one step toward the head.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.pop) begin
      valid_d = next_valid_i;
      data_d  = next_data_i;
    end else if (take_load) begin
      valid_d = 1'b1;
      data_d  = load_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/dlm_chain.sv */
// A row of dlm_cell instances holding one list, head at position zero.
// Depends on dlm_pkg and dlm_cell.
module dlm_chain import dlm_pkg::*; #(
  parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] load_data_i,
  output logic              head_valid_o,
  output logic [DATA_W-1:0] head_data_o
);

  logic              valid_w [LIST_DEPTH];
  logic [DATA_W-1:0] data_w  [LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic              prev_valid;
    logic              next_valid;
    logic [DATA_W-1:0] next_data;

    // The head has no predecessor; the tail refills with an empty slot.
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = valid_w[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_data  = '0;
    end else begin : g_inner
      assign next_valid = valid_w[i+1];
      assign next_data  = data_w[i+1];
    end

    dlm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .load_data_i  (load_data_i),
      .prev_valid_i (prev_valid),
      .next_valid_i (next_valid),
      .next_data_i  (next_data),
      .valid_o      (valid_w[i]),
      .data_o       (data_w[i])
    );
  end

  assign head_valid_o = valid_w[0];
  assign head_data_o  = data_w[0];

endmodule
